// ===== design/fdsf_pkg.sv =====
// Shared types and constants for the fractional-delay shift FIR.
// No dependencies; used by the stream interfaces and the top level.
package fdsf_pkg;

  localparam int SampleWidth = 24;
  localparam int CoefWidth   = 12;
  // four products of a sample and a coefficient, plus rounding headroom
  localparam int AccWidth    = SampleWidth + CoefWidth + 2;
  localparam int FracBits    = 10;
  localparam int QuotWidth   = AccWidth - FracBits;

  // tail length covered by the flush after the last word of a run
  localparam int FlushMax    = 8;
  localparam int SatCount    = 9;
  localparam int CountWidth  = $clog2(SatCount + 1);
  localparam int FlushWidth  = $clog2(FlushMax + 1);
  localparam int TapSelWidth = $clog2(FlushMax);

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [CoefWidth-1:0]   coef_t;
  typedef logic signed [AccWidth-1:0]    acc_t;
  typedef logic signed [QuotWidth-1:0]   quot_t;
  typedef logic [CountWidth-1:0]         count_t;
  typedef logic [FlushWidth-1:0]         flush_t;
  typedef logic [TapSelWidth-1:0]        tap_sel_t;

  // Q10 cubic interpolation weights for samples i+5 .. i+8
  localparam coef_t CoefA = -12'sd7;
  localparam coef_t CoefB = 12'sd93;
  localparam coef_t CoefC = 12'sd987;
  localparam coef_t CoefD = -12'sd49;

  localparam acc_t RoundHalf = acc_t'(1) <<< (FracBits - 1);

  localparam sample_t SampleMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleWidth-1){1'b0}}};

  // flush steps whose taps reach back into history
  localparam tap_sel_t TapSelFar  = tap_sel_t'(FlushMax - 1);
  localparam tap_sel_t TapSelNear = tap_sel_t'(FlushMax - 2);

  localparam count_t CountFull = count_t'(FlushMax);
  localparam count_t CountSat  = count_t'(SatCount);

endpackage

// ===== design/fdsf_if.sv =====
// Valid/ready stream interfaces for the input and result words.
// Depends on fdsf_pkg for the sample type.
interface fdsf_in_if import fdsf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface fdsf_out_if import fdsf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    last_out;

  modport source (output valid, output sample_out, output last_out, input ready);
  modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

// ===== design/fractional_delay_shift_fir.sv =====
// Fractional-delay shift FIR: four-tap cubic interpolator that advances a run
// of samples by 6.875 samples. Depends on fdsf_pkg and the fdsf_if streams.
//
// Usage:
//   in_i carries one sample word per handshake; last_in marks the end of a run.
//   out_o carries the interpolated, rounded and saturated words, last_out on
//   the final word of each run. Every run yields as many words as it took.
//   The first eight words of a run produce nothing; each later word produces
//   one result word, held in the tap register and then the result register.
//   Throughput is one word per cycle while out_o does not stall. The word marked
//   last is followed by a flush of min(run length, 8) extra result words, one per
//   cycle from the flush sequencer while out_o keeps up; in_i.ready stays low while it runs.
//   When out_o stalls, the result register holds and the tap register behind
//   it fills; in_i.ready then drops until the result word is taken.
//   Reset (rst_ni low, asynchronous) empties both registers, stops any flush
//   and clears the sample history and the run counter.
module fractional_delay_shift_fir
  import fdsf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  fdsf_in_if.sink         in_i,
  fdsf_out_if.source      out_o
);

  function automatic sample_t interp(sample_t a, sample_t b, sample_t c, sample_t d);
    acc_t  acc;
    quot_t q;
    acc = acc_t'(a) * acc_t'(CoefA) + acc_t'(b) * acc_t'(CoefB)
        + acc_t'(c) * acc_t'(CoefC) + acc_t'(d) * acc_t'(CoefD) + RoundHalf;
    q = quot_t'(acc >>> FracBits);
    if (q > quot_t'(SampleMax)) begin
      return SampleMax;
    end else if (q < quot_t'(SampleMin)) begin
      return SampleMin;
    end
    return sample_t'(q);
  endfunction

  // run state
  sample_t hist_q [3];
  count_t  count_q;

  // flush context: t0 = last word, t1/t2 = words before it
  sample_t tail_q [3];
  flush_t  flush_q;

  // tap register
  logic    a_valid_q;
  sample_t a_tap_q [4];
  logic    a_last_q;

  // result register
  logic    b_valid_q;
  sample_t b_sample_q;
  logic    b_last_q;

  logic     b_load;
  logic     a_load;
  logic     in_fire;
  logic     flush_step;
  logic     regular;
  tap_sel_t flush_m;
  flush_t   flush_len;

  assign b_load     = !b_valid_q || out_o.ready;
  assign a_load     = !a_valid_q || b_load;
  assign in_i.ready = (flush_q == '0) && a_load;
  assign in_fire    = in_i.valid && in_i.ready;
  assign flush_step = (flush_q != '0) && a_load;
  assign regular    = count_q >= CountFull;
  assign flush_m    = tap_sel_t'(flush_q - flush_t'(1));
  assign flush_len  = regular ? flush_t'(FlushMax) : flush_t'(count_q + count_t'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '{default: '0};
      count_q <= '0;
      flush_q <= '0;
    end else begin
      if (in_fire) begin
        if (in_i.last_in) begin
          hist_q  <= '{default: '0};
          count_q <= '0;
          flush_q <= flush_len;
        end else begin
          hist_q[2] <= hist_q[1];
          hist_q[1] <= hist_q[0];
          hist_q[0] <= in_i.sample_in;
          if (count_q < CountSat) begin
            count_q <= count_q + count_t'(1);
          end
        end
      end else if (flush_step) begin
        flush_q <= flush_q - flush_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.last_in) begin
      tail_q[0] <= in_i.sample_in;
      tail_q[1] <= hist_q[0];
      tail_q[2] <= hist_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_load) begin
      a_valid_q <= (in_fire && regular) || flush_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      if (flush_step) begin
        a_last_q <= (flush_m == '0);
        if (flush_m == TapSelFar) begin
          a_tap_q <= '{tail_q[2], tail_q[1], tail_q[0], tail_q[0]};
        end else if (flush_m == TapSelNear) begin
          a_tap_q <= '{tail_q[1], tail_q[0], tail_q[0], tail_q[0]};
        end else begin
          a_tap_q <= '{default: tail_q[0]};
        end
      end else begin
        a_last_q <= 1'b0;
        a_tap_q  <= '{hist_q[2], hist_q[1], hist_q[0], in_i.sample_in};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_load) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load && a_valid_q) begin
      b_sample_q <= interp(a_tap_q[0], a_tap_q[1], a_tap_q[2], a_tap_q[3]);
      b_last_q   <= a_last_q;
    end
  end

  assign out_o.valid      = b_valid_q;
  assign out_o.sample_out = b_sample_q;
  assign out_o.last_out   = b_last_q;

  // a closing word in the tap register means the flush has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && a_last_q |-> flush_q == '0)
    else $error("closing word staged while flush still pending");

  // a long run ends with a full flush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.last_in && regular |=> flush_q == flush_t'(FlushMax))
    else $error("flush length wrong after long run");

  // flush never exceeds the tail length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q <= flush_t'(FlushMax))
    else $error("flush counter out of range");

  // the run counter restarts after every closing word and in_i.ready drops for the flush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.last_in |=> count_q == '0 && !in_i.ready)
    else $error("run state not cleared at end of run");

endmodule

// ===== tb/fractional_delay_shift_fir_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fractional_delay_shift_fir: runs of sample words
// go in, results are checked against an in-bench interpolator model.
// Depends on fdsf_pkg and the fdsf_in_if / fdsf_out_if stream interfaces.
module fractional_delay_shift_fir_test import fdsf_pkg::*; ();

  localparam int StallLimit  = 256;
  localparam int DrainCycles = 16;
  localparam int RandWords   = 340;
  localparam int QuietFrom   = 280;
  localparam int PauseAt     = 150;

  typedef struct packed {
    sample_t smp;
    logic    is_last;
  } fir_word_t;

  typedef struct packed {
    sample_t smp;
    logic    is_last;
    logic    typed;
    sample_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  fdsf_in_if  in_bus ();
  fdsf_out_if out_bus ();

  fractional_delay_shift_fir u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // directed words: one-word runs, then two runs that push the sum past both rails
  dir_row_t dir_tab [25] = '{
    '{SampleMax, 1'b1, 1'b1, SampleMax},
    '{SampleMin, 1'b1, 1'b1, SampleMin},
    '{sample_t'(0), 1'b1, 1'b1, sample_t'(0)},
    '{sample_t'(-1), 1'b1, 1'b1, sample_t'(-1)},
    '{sample_t'(17), 1'b0, 1'b0, sample_t'(0)},
    '{sample_t'(-17), 1'b0, 1'b0, sample_t'(0)},
    '{sample_t'(4095), 1'b0, 1'b0, sample_t'(0)},
    '{sample_t'(-4096), 1'b0, 1'b0, sample_t'(0)},
    '{sample_t'(1), 1'b0, 1'b0, sample_t'(0)},
    '{SampleMin, 1'b0, 1'b0, sample_t'(0)},
    '{SampleMax, 1'b0, 1'b0, sample_t'(0)},
    '{SampleMax, 1'b0, 1'b0, sample_t'(0)},
    '{SampleMin, 1'b1, 1'b0, sample_t'(0)},
    '{sample_t'(0), 1'b0, 1'b0, sample_t'(0)},
    '{sample_t'(-1), 1'b0, 1'b0, sample_t'(0)},
    '{sample_t'(2), 1'b0, 1'b0, sample_t'(0)},
    '{sample_t'(-3), 1'b0, 1'b0, sample_t'(0)},
    '{sample_t'(4), 1'b0, 1'b0, sample_t'(0)},
    '{SampleMax, 1'b0, 1'b0, sample_t'(0)},
    '{SampleMin, 1'b0, 1'b0, sample_t'(0)},
    '{SampleMin, 1'b0, 1'b0, sample_t'(0)},
    '{SampleMax, 1'b0, 1'b0, sample_t'(0)},
    '{SampleMin, 1'b0, 1'b0, sample_t'(0)},
    '{SampleMax, 1'b0, 1'b0, sample_t'(0)},
    '{SampleMax, 1'b1, 1'b0, sample_t'(0)}
  };

  fir_word_t expected_q [$];
  fir_word_t got_head;

  longint hist [3];
  int     run_len;

  int errors;
  int words_in;
  int runs_done;
  int words_checked;
  int rail_hits;
  int idle_cnt;
  int sink_left;
  logic sink_mode;
  bit quiet;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic sample_t interp4(longint a, longint b, longint c, longint d);
    longint acc;
    longint quo;
    acc = longint'(CoefA) * a + longint'(CoefB) * b + longint'(CoefC) * c
        + longint'(CoefD) * d + longint'(RoundHalf);
    quo = acc >>> FracBits;
    if (quo > longint'(SampleMax)) quo = longint'(SampleMax);
    if (quo < longint'(SampleMin)) quo = longint'(SampleMin);
    return sample_t'(quo);
  endfunction

  function automatic void clear_history();
    hist[0] = 0;
    hist[1] = 0;
    hist[2] = 0;
    run_len = 0;
  endfunction

  // expected results caused by one accepted word
  function automatic void predict_word(sample_t smp, logic is_last);
    longint tail [3];
    longint tap [4];
    int n_flush;
    int back;
    if (run_len >= FlushMax)
      expected_q.push_back('{interp4(hist[2], hist[1], hist[0], smp), 1'b0});
    if (is_last) begin
      tail[0] = smp;
      tail[1] = hist[0];
      tail[2] = hist[1];
      n_flush = (run_len + 1 < FlushMax) ? run_len + 1 : FlushMax;
      for (int m = n_flush - 1; m >= 0; m--) begin
        for (int k = 0; k < 4; k++) begin
          back = m - 5 - k;
          tap[k] = (back <= 0) ? tail[0] : tail[back];
        end
        expected_q.push_back('{interp4(tap[0], tap[1], tap[2], tap[3]), m == 0});
      end
      clear_history();
      runs_done++;
    end else begin
      hist[2] = hist[1];
      hist[1] = hist[0];
      hist[0] = smp;
      if (run_len < SatCount) run_len++;
    end
  endfunction

  task automatic send_word(sample_t smp, logic is_last);
    @(negedge clk_i);
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= smp;
    in_bus.last_in   <= is_last;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    words_in++;
  endtask

  task automatic maybe_idle();
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      @(negedge clk_i);
      in_bus.valid     <= 1'b0;
      in_bus.sample_in <= sample_t'($urandom);
      in_bus.last_in   <= 1'($urandom_range(0, 1));
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SampleMax;
      1: return SampleMin;
      2, 3: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int pick_run_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(1, 8);
      4, 5, 6, 7: return $urandom_range(9, 20);
      8: return $urandom_range(21, 60);
      default: return 1;
    endcase
  endfunction

  // result side: ready in random bursts, always high once quiet
  initial begin
    out_bus.ready = 1'b0;
    sink_left     = 0;
    sink_mode     = 1'b1;
    forever begin
      @(negedge clk_i);
      if (sink_left == 0) begin
        if (!quiet && $urandom_range(0, 3) == 0) begin
          sink_mode = 1'b0;
          sink_left = $urandom_range(1, 8);
        end else begin
          sink_mode = 1'b1;
          sink_left = $urandom_range(1, 16);
        end
      end
      sink_left--;
      out_bus.ready <= quiet ? 1'b1 : sink_mode;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word sample %0d last %0b", $time,
                 out_bus.sample_out, out_bus.last_out);
        errors++;
      end else begin
        got_head = expected_q.pop_front();
        words_checked++;
        if (out_bus.sample_out == SampleMax || out_bus.sample_out == SampleMin)
          rail_hits++;
        if (out_bus.sample_out !== got_head.smp) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d", $time,
                   got_head.smp, out_bus.sample_out);
          errors++;
        end
        if (out_bus.last_out !== got_head.is_last) begin
          $display("%0t: last_out mismatch, expected %0b, got %0b", $time,
                   got_head.is_last, out_bus.last_out);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int n_words;
    int rand_words;
    bit paused;
    sample_t smp;
    errors           = 0;
    words_in         = 0;
    runs_done        = 0;
    words_checked    = 0;
    rail_hits        = 0;
    idle_cnt         = 0;
    quiet            = 1'b0;
    paused           = 1'b0;
    rand_words       = 0;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    in_bus.last_in   = 1'b0;
    clear_history();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].smp, dir_tab[i].is_last);
      if (dir_tab[i].typed) begin
        expected_q.push_back('{dir_tab[i].want, 1'b1});
        clear_history();
        runs_done++;
      end else begin
        predict_word(dir_tab[i].smp, dir_tab[i].is_last);
      end
      maybe_idle();
    end

    while (rand_words < RandWords) begin
      n_words = pick_run_len();
      for (int j = 0; j < n_words; j++) begin
        smp = pick_sample();
        send_word(smp, j == n_words - 1);
        predict_word(smp, j == n_words - 1);
        rand_words++;
        if (rand_words >= QuietFrom) quiet = 1'b1;
        maybe_idle();
      end
      if (!paused && rand_words >= PauseAt) begin
        paused = 1'b1;
        @(negedge clk_i);
        in_bus.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk_i);
      end
    end

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d sample words in %0d runs, run lengths 1 to 60", words_in, runs_done);
    $display("%0d result words checked, %0d at a rail", words_checked, rail_hits);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
